// ===== design/mcfe_pkg.sv =====
// shared types and constants of the command frame encoder
package mcfe_pkg;

    // value and field widths
    localparam int DATA_W       = 32;
    localparam int LIMIT_W      = 31;
    localparam int FRAME_ID_W   = 11;
    localparam int POS_CODE_W   = 16;
    localparam int FIELD_CODE_W = 12;
    localparam int BYTE_W       = 8;

    // stream and register port widths
    localparam int S_TDATA_W = 160;
    localparam int M_TDATA_W = 80;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;

    // register values after reset
    localparam logic [LIMIT_W-1:0]    POS_LIMIT_RST    = 31'd819200;
    localparam logic [LIMIT_W-1:0]    VEL_LIMIT_RST    = 31'd1966080;
    localparam logic [LIMIT_W-1:0]    TORQUE_LIMIT_RST = 31'd655360;
    localparam logic [DATA_W-1:0]     STIFF_MIN_RST    = 32'd0;
    localparam logic [DATA_W-1:0]     STIFF_MAX_RST    = 32'd32768000;
    localparam logic [DATA_W-1:0]     DAMP_MIN_RST     = 32'd0;
    localparam logic [DATA_W-1:0]     DAMP_MAX_RST     = 32'd327680;
    localparam logic [FRAME_ID_W-1:0] FRAME_ID_RST     = 11'd1;

    // register index, taken from paddr word bits
    typedef enum logic [2:0] {
        REG_POS_LIMIT    = 3'd0,
        REG_VEL_LIMIT    = 3'd1,
        REG_TORQUE_LIMIT = 3'd2,
        REG_STIFF_MIN    = 3'd3,
        REG_STIFF_MAX    = 3'd4,
        REG_DAMP_MIN     = 3'd5,
        REG_DAMP_MAX     = 3'd6,
        REG_FRAME_ID     = 3'd7
    } reg_idx_t;

    // configuration register set
    typedef struct packed {
        logic [LIMIT_W-1:0]       pos_limit;
        logic [LIMIT_W-1:0]       vel_limit;
        logic [LIMIT_W-1:0]       torque_limit;
        logic signed [DATA_W-1:0] stiff_min;
        logic signed [DATA_W-1:0] stiff_max;
        logic signed [DATA_W-1:0] damp_min;
        logic signed [DATA_W-1:0] damp_max;
        logic [FRAME_ID_W-1:0]    frame_id;
    } cfg_t;

    // input word, first field in the highest bits
    typedef struct packed {
        logic [DATA_W-1:0] torque_ff;
        logic [DATA_W-1:0] damp_gain;
        logic [DATA_W-1:0] stiff_gain;
        logic [DATA_W-1:0] vel_target;
        logic [DATA_W-1:0] pos_target;
    } cmd_t;

    // output word, first field in the highest bits
    typedef struct packed {
        logic [4:0]            pad;
        logic [BYTE_W-1:0]     byte7;
        logic [BYTE_W-1:0]     byte6;
        logic [BYTE_W-1:0]     byte5;
        logic [BYTE_W-1:0]     byte4;
        logic [BYTE_W-1:0]     byte3;
        logic [BYTE_W-1:0]     byte2;
        logic [BYTE_W-1:0]     byte1;
        logic [BYTE_W-1:0]     byte0;
        logic [FRAME_ID_W-1:0] out_id;
    } frame_t;

endpackage

// ===== design/mit_command_frame_encoder.sv =====
// top level of the mit-mode motor command frame encoder
//
// Usage:
//   s_* stream takes one motor command per word (five signed Q16.16 values);
//   m_* stream gives one frame per command: the frame identifier and the
//   eight payload bytes. The register bus port holds the ranges and the id;
//   write it only while no command is in flight.
// Throughput: one command per cycle while the receiver takes words.
// Pipeline: three front stages (compare, clamp and offset, scaling), then
//   the division, which yields one quotient bit per stage in every lane,
//   then the output register.
// Reset: the configuration registers return to their reset values, the valid
//   bits clear so the pipeline empties, m_tvalid goes low and s_tready goes high.
// Stall: when m_tready is low the output word holds; the word behind it
//   moves into a skid register, then s_tready drops and the pipeline
//   freezes in place until the receiver takes a word.
module mit_command_frame_encoder
    import mcfe_pkg::*;
#(
    parameter int POS_BITS   = 16,
    parameter int FIELD_BITS = 12
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // register bus
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready,
    // command words
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // pos_target, vel_target, stiff_gain, damp_gain, torque_ff
    input  logic [S_TDATA_W-1:0] s_tdata,
    // frame words
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // out_id, byte0 .. byte7, zero pad
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int DIV_STEPS = (POS_BITS > FIELD_BITS) ? POS_BITS : FIELD_BITS;
    localparam int LAT       = 3 + DIV_STEPS;

    cfg_t                     cfg;
    cmd_t                     cmd;
    logic signed [DATA_W-1:0] pos_hi;
    logic signed [DATA_W-1:0] pos_lo;
    logic signed [DATA_W-1:0] vel_hi;
    logic signed [DATA_W-1:0] vel_lo;
    logic signed [DATA_W-1:0] trq_hi;
    logic signed [DATA_W-1:0] trq_lo;
    logic [POS_BITS-1:0]      pos_code;
    logic [FIELD_BITS-1:0]    vel_code;
    logic [FIELD_BITS-1:0]    stiff_code;
    logic [FIELD_BITS-1:0]    damp_code;
    logic [FIELD_BITS-1:0]    trq_code;
    logic [POS_CODE_W-1:0]    p16;
    logic [FIELD_CODE_W-1:0]  v12;
    logic [FIELD_CODE_W-1:0]  kp12;
    logic [FIELD_CODE_W-1:0]  kd12;
    logic [FIELD_CODE_W-1:0]  t12;
    frame_t                   pack_word;
    logic                     pipe_en;
    logic [LAT-1:0]           v_reg;
    logic [LAT-1:0]           v_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    frame_t                   out_data_reg;
    frame_t                   out_data_next;
    logic                     skid_valid_reg;
    logic                     skid_valid_next;
    frame_t                   skid_data_reg;
    frame_t                   skid_data_next;

    // configuration registers
    mcfe_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    // symmetric bounds from the half-widths
    assign pos_hi = {1'b0, cfg.pos_limit};
    assign pos_lo = -pos_hi;
    assign vel_hi = {1'b0, cfg.vel_limit};
    assign vel_lo = -vel_hi;
    assign trq_hi = {1'b0, cfg.torque_limit};
    assign trq_lo = -trq_hi;

    assign cmd = s_tdata;

    // whole pipeline moves together while the skid register is free
    assign pipe_en  = !skid_valid_reg;
    assign s_tready = pipe_en;

    // quantizer lanes
    mcfe_quant #(.BITS(POS_BITS), .STEPS(DIV_STEPS)) u_pos (
        .clk  (clk),
        .en   (pipe_en),
        .x    (cmd.pos_target),
        .lo   (pos_lo),
        .hi   (pos_hi),
        .code (pos_code)
    );

    mcfe_quant #(.BITS(FIELD_BITS), .STEPS(DIV_STEPS)) u_vel (
        .clk  (clk),
        .en   (pipe_en),
        .x    (cmd.vel_target),
        .lo   (vel_lo),
        .hi   (vel_hi),
        .code (vel_code)
    );

    mcfe_quant #(.BITS(FIELD_BITS), .STEPS(DIV_STEPS)) u_stiff (
        .clk  (clk),
        .en   (pipe_en),
        .x    (cmd.stiff_gain),
        .lo   (cfg.stiff_min),
        .hi   (cfg.stiff_max),
        .code (stiff_code)
    );

    mcfe_quant #(.BITS(FIELD_BITS), .STEPS(DIV_STEPS)) u_damp (
        .clk  (clk),
        .en   (pipe_en),
        .x    (cmd.damp_gain),
        .lo   (cfg.damp_min),
        .hi   (cfg.damp_max),
        .code (damp_code)
    );

    mcfe_quant #(.BITS(FIELD_BITS), .STEPS(DIV_STEPS)) u_trq (
        .clk  (clk),
        .en   (pipe_en),
        .x    (cmd.torque_ff),
        .lo   (trq_lo),
        .hi   (trq_hi),
        .code (trq_code)
    );

    // frame byte packing
    always_comb
    begin
        p16  = POS_CODE_W'(pos_code);
        v12  = FIELD_CODE_W'(vel_code);
        kp12 = FIELD_CODE_W'(stiff_code);
        kd12 = FIELD_CODE_W'(damp_code);
        t12  = FIELD_CODE_W'(trq_code);

        pack_word.pad    = '0;
        pack_word.out_id = cfg.frame_id;
        pack_word.byte0  = p16[15:8];
        pack_word.byte1  = p16[7:0];
        pack_word.byte2  = v12[11:4];
        pack_word.byte3  = {v12[3:0], kp12[11:8]};
        pack_word.byte4  = kp12[7:0];
        pack_word.byte5  = kd12[11:4];
        pack_word.byte6  = {kd12[3:0], t12[11:8]};
        pack_word.byte7  = t12[7:0];
    end

    // valid bits travel with the stages
    assign v_next = pipe_en ? {v_reg[LAT-2:0], s_tvalid} : v_reg;

    // output register with one skid entry behind it
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (pipe_en)
        begin
            if (!out_valid_reg || m_tready)
            begin
                out_valid_next = v_reg[LAT-1];
                out_data_next  = pack_word;
            end
            else
            begin
                skid_valid_next = v_reg[LAT-1];
                skid_data_next  = pack_word;
            end
        end
        else if (m_tready)
        begin
            out_valid_next  = 1'b1;
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg          <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            v_reg          <= v_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== design/mcfe_regs.sv =====
// configuration registers behind the register bus port
module mcfe_regs
    import mcfe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output cfg_t               cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx   = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    // register write decode, upper bits of wide data dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_POS_LIMIT:    cfg_next.pos_limit    = pwdata[LIMIT_W-1:0];
                REG_VEL_LIMIT:    cfg_next.vel_limit    = pwdata[LIMIT_W-1:0];
                REG_TORQUE_LIMIT: cfg_next.torque_limit = pwdata[LIMIT_W-1:0];
                REG_STIFF_MIN:    cfg_next.stiff_min    = pwdata[DATA_W-1:0];
                REG_STIFF_MAX:    cfg_next.stiff_max    = pwdata[DATA_W-1:0];
                REG_DAMP_MIN:     cfg_next.damp_min     = pwdata[DATA_W-1:0];
                REG_DAMP_MAX:     cfg_next.damp_max     = pwdata[DATA_W-1:0];
                REG_FRAME_ID:     cfg_next.frame_id     = pwdata[FRAME_ID_W-1:0];
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (idx)
            REG_POS_LIMIT:    prdata = PDATA_W'(cfg_reg.pos_limit);
            REG_VEL_LIMIT:    prdata = PDATA_W'(cfg_reg.vel_limit);
            REG_TORQUE_LIMIT: prdata = PDATA_W'(cfg_reg.torque_limit);
            REG_STIFF_MIN:    prdata = PDATA_W'(unsigned'(cfg_reg.stiff_min));
            REG_STIFF_MAX:    prdata = PDATA_W'(unsigned'(cfg_reg.stiff_max));
            REG_DAMP_MIN:     prdata = PDATA_W'(unsigned'(cfg_reg.damp_min));
            REG_DAMP_MAX:     prdata = PDATA_W'(unsigned'(cfg_reg.damp_max));
            REG_FRAME_ID:     prdata = PDATA_W'(cfg_reg.frame_id);
        endcase
    end

    // register storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pos_limit    <= POS_LIMIT_RST;
            cfg_reg.vel_limit    <= VEL_LIMIT_RST;
            cfg_reg.torque_limit <= TORQUE_LIMIT_RST;
            cfg_reg.stiff_min    <= STIFF_MIN_RST;
            cfg_reg.stiff_max    <= STIFF_MAX_RST;
            cfg_reg.damp_min     <= DAMP_MIN_RST;
            cfg_reg.damp_max     <= DAMP_MAX_RST;
            cfg_reg.frame_id     <= FRAME_ID_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== design/mcfe_div_step.sv =====
// one registered restoring division step, one quotient bit per stage
module mcfe_div_step
    import mcfe_pkg::*;
#(
    parameter int STEPS = 16
)
(
    input  logic              clk,
    input  logic              en,
    input  logic [DATA_W-1:0] span,
    input  logic [DATA_W-1:0] rem_in,
    input  logic [STEPS-1:0]  num_in,
    input  logic [STEPS-1:0]  quo_in,
    output logic [DATA_W-1:0] rem_out,
    output logic [STEPS-1:0]  num_out,
    output logic [STEPS-1:0]  quo_out
);

    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;
    logic              ge;
    logic [DATA_W-1:0] rem_next;
    logic [STEPS-1:0]  num_next;
    logic [STEPS-1:0]  quo_next;
    logic [DATA_W-1:0] rem_reg;
    logic [STEPS-1:0]  num_reg;
    logic [STEPS-1:0]  quo_reg;

    // shift in the next numerator bit, subtract the divisor if it fits
    always_comb
    begin
        trial    = {rem_in, num_in[STEPS-1]};
        diff     = trial - {1'b0, span};
        ge       = trial >= {1'b0, span};
        rem_next = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        num_next = num_in << 1;
        quo_next = STEPS'({quo_in, ge});
    end

    // stage register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            num_reg <= num_next;
            quo_reg <= quo_next;
        end
    end

    assign rem_out = rem_reg;
    assign num_out = num_reg;
    assign quo_out = quo_reg;

endmodule

// ===== design/mcfe_quant.sv =====
// one quantizer lane: clamp, offset, scale by 2^bits-1, then divide by the span
module mcfe_quant
    import mcfe_pkg::*;
#(
    parameter int BITS  = 12,
    parameter int STEPS = 16
)
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [DATA_W-1:0] x,
    input  logic signed [DATA_W-1:0] lo,
    input  logic signed [DATA_W-1:0] hi,
    output logic [BITS-1:0]          code
);

    localparam int NUM_W = DATA_W + STEPS;

    logic [DATA_W-1:0]        span_next;
    logic [DATA_W-1:0]        span_reg;
    logic                     empty_next;
    logic                     empty_reg;
    logic signed [DATA_W-1:0] x_reg;
    logic                     lt_next;
    logic                     gt_next;
    logic                     lt_reg;
    logic                     gt_reg;
    logic signed [DATA_W-1:0] clamped;
    logic [DATA_W-1:0]        off_next;
    logic [DATA_W-1:0]        off_reg;
    logic [NUM_W-1:0]         num_next;
    logic [NUM_W-1:0]         num_reg;

    logic [DATA_W-1:0] rem_w [0:STEPS];
    logic [STEPS-1:0]  bits_w [0:STEPS];
    logic [STEPS-1:0]  quo_w [0:STEPS];

    // span/empty follow registers; user holds them still while busy; unenforced
    assign span_next  = unsigned'(hi - lo);
    assign empty_next = hi <= lo;

    always_ff @(posedge clk)
    begin
        span_reg  <= span_next;
        empty_reg <= empty_next;
    end

    // stage 1: range compares
    assign lt_next = x < lo;
    assign gt_next = x > hi;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg  <= x;
            lt_reg <= lt_next;
            gt_reg <= gt_next;
        end
    end

    // stage 2: clamp and offset from the low bound
    always_comb
    begin
        priority if (lt_reg)
            clamped = lo;
        else if (gt_reg)
            clamped = hi;
        else
            clamped = x_reg;
        off_next = unsigned'(clamped - lo);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            off_reg <= off_next;
        end
    end

    // stage 3: times 2^bits-1 as a shift and a subtract
    assign num_next = (NUM_W'(off_reg) << BITS) - NUM_W'(off_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= num_next;
        end
    end

    // division stages; high part of the product is already below the span
    assign rem_w[0]  = num_reg[NUM_W-1:STEPS];
    assign bits_w[0] = num_reg[STEPS-1:0];
    assign quo_w[0]  = '0;

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        mcfe_div_step #(
            .STEPS (STEPS)
        ) u_step (
            .clk     (clk),
            .en      (en),
            .span    (span_reg),
            .rem_in  (rem_w[k]),
            .num_in  (bits_w[k]),
            .quo_in  (quo_w[k]),
            .rem_out (rem_w[k+1]),
            .num_out (bits_w[k+1]),
            .quo_out (quo_w[k+1])
        );
    end

    // empty range gives code zero
    assign code = empty_reg ? '0 : quo_w[STEPS][BITS-1:0];

endmodule

// ===== design/mcfe_checker.sv =====
// port-level checks of the command frame encoder, bound to the top level
module mcfe_checker
    import mcfe_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // a stalled output word stays and holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    // a cycle held in reset empties the output and frees the input
    a_reset_state: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid && s_tready)
        else $error("output valid or input blocked after reset");

    // input only blocks when an output word is waiting
    a_block_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input blocked with no output word waiting");

    // one taken word frees the input again
    a_unblock: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready && m_tready |=> s_tready)
        else $error("input still blocked after output word taken");

    // pad bits above the last byte are zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[M_TDATA_W-1:75] == '0)
        else $error("nonzero pad bits in output word");

endmodule

bind mit_command_frame_encoder mcfe_checker u_mcfe_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/sv/tb.sv =====
// testbench for the mit-mode command frame encoder: stream commands in, checked frames out
module tb
    import mcfe_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY    = 4 + POS_CODE_W;
    localparam int NUM_PHASES = 8;
    localparam int PHASE_CMDS = 80;
    localparam int MAX_REPORTS = 50;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // pos_target, vel_target, stiff_gain, damp_gain, torque_ff
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // out_id, byte0 .. byte7, zero pad
    logic [M_TDATA_W-1:0] m_tdata;

    // commands waiting to be sent, frames predicted but not yet seen
    cmd_t   cmd_q[$];
    frame_t frame_q[$];
    // register copy used for prediction
    cfg_t   enc_cfg;

    logic   idle_on = 1'b1;
    logic   in_taken = 1'b0;
    int     in_gap = 0;
    int     out_gap = 0;
    int     err_count = 0;
    int     cmds_sent = 0;
    int     frames_seen = 0;

    mit_command_frame_encoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // clamp to [lo,hi] and scale truncating onto 0 .. 2^nbits-1; empty range gives 0
    function automatic logic [15:0] scale_code(longint x, longint lo, longint hi, int nbits);
        longint unsigned off;
        longint unsigned span;
        longint unsigned steps;
        longint unsigned q;
        if (hi <= lo)
            return '0;
        if (x < lo)
            x = lo;
        else if (x > hi)
            x = hi;
        steps = (64'd1 << nbits) - 64'd1;
        span  = hi - lo;
        off   = x - lo;
        q     = (off * steps) / span;
        return q[15:0];
    endfunction

    // expected frame for one command under the current registers
    function automatic frame_t encode_frame(cmd_t c);
        frame_t f;
        logic [15:0] p;
        logic [15:0] v;
        logic [15:0] kp;
        logic [15:0] kd;
        logic [15:0] t;
        p  = scale_code(longint'($signed(c.pos_target)), -longint'(enc_cfg.pos_limit),
                        longint'(enc_cfg.pos_limit), POS_CODE_W);
        v  = scale_code(longint'($signed(c.vel_target)), -longint'(enc_cfg.vel_limit),
                        longint'(enc_cfg.vel_limit), FIELD_CODE_W);
        kp = scale_code(longint'($signed(c.stiff_gain)), longint'($signed(enc_cfg.stiff_min)),
                        longint'($signed(enc_cfg.stiff_max)), FIELD_CODE_W);
        kd = scale_code(longint'($signed(c.damp_gain)), longint'($signed(enc_cfg.damp_min)),
                        longint'($signed(enc_cfg.damp_max)), FIELD_CODE_W);
        t  = scale_code(longint'($signed(c.torque_ff)), -longint'(enc_cfg.torque_limit),
                        longint'(enc_cfg.torque_limit), FIELD_CODE_W);
        f        = '0;
        f.out_id = enc_cfg.frame_id;
        f.byte0  = p[15:8];
        f.byte1  = p[7:0];
        f.byte2  = v[11:4];
        f.byte3  = {v[3:0], kp[11:8]};
        f.byte4  = kp[7:0];
        f.byte5  = kd[11:4];
        f.byte6  = {kd[3:0], t[11:8]};
        f.byte7  = t[7:0];
        return f;
    endfunction

    // value biased toward a range and its edges, clipped to 32 bit signed
    function automatic logic [31:0] pick_value(longint lo, longint hi);
        longint v;
        longint w;
        longint unsigned r;
        case ($urandom_range(0, 3))
            0: v = longint'($signed($urandom));
            1: v = ($urandom_range(0, 1) ? lo : hi) + longint'($urandom_range(0, 6)) - 3;
            default:
            begin
                w = (hi > lo) ? hi - lo : 64;
                r = {$urandom, $urandom};
                v = lo - w / 8 + longint'(r % (w + w / 4 + 1));
            end
        endcase
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t c;
        c.pos_target = pick_value(-longint'(enc_cfg.pos_limit), longint'(enc_cfg.pos_limit));
        c.vel_target = pick_value(-longint'(enc_cfg.vel_limit), longint'(enc_cfg.vel_limit));
        c.stiff_gain = pick_value(longint'($signed(enc_cfg.stiff_min)),
                                  longint'($signed(enc_cfg.stiff_max)));
        c.damp_gain  = pick_value(longint'($signed(enc_cfg.damp_min)),
                                  longint'($signed(enc_cfg.damp_max)));
        c.torque_ff  = pick_value(-longint'(enc_cfg.torque_limit),
                                  longint'(enc_cfg.torque_limit));
        return c;
    endfunction

    task automatic push_cmd(logic [31:0] p, logic [31:0] v, logic [31:0] k, logic [31:0] d,
                            logic [31:0] t);
        cmd_t c;
        c.pos_target = p;
        c.vel_target = v;
        c.stiff_gain = k;
        c.damp_gain  = d;
        c.torque_ff  = t;
        cmd_q.push_back(c);
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (err_count < MAX_REPORTS)
            $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // one register bus transfer: setup phase, then access until pready
    task automatic bus_access(reg_idx_t idx, logic wr, logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = {idx, 2'b00};
        pwdata  = wdata;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        logic [31:0] unused;
        bus_access(idx, 1'b1, val, unused);
        // upper bits beyond each register's width are dropped
        case (idx)
            REG_POS_LIMIT:    enc_cfg.pos_limit    = val[LIMIT_W-1:0];
            REG_VEL_LIMIT:    enc_cfg.vel_limit    = val[LIMIT_W-1:0];
            REG_TORQUE_LIMIT: enc_cfg.torque_limit = val[LIMIT_W-1:0];
            REG_STIFF_MIN:    enc_cfg.stiff_min    = val;
            REG_STIFF_MAX:    enc_cfg.stiff_max    = val;
            REG_DAMP_MIN:     enc_cfg.damp_min     = val;
            REG_DAMP_MAX:     enc_cfg.damp_max     = val;
            REG_FRAME_ID:     enc_cfg.frame_id     = val[FRAME_ID_W-1:0];
            default: ;
        endcase
    endtask

    task automatic check_reg(reg_idx_t idx);
        logic [31:0] rd;
        logic [31:0] want;
        bus_access(idx, 1'b0, '0, rd);
        case (idx)
            REG_POS_LIMIT:    want = {1'b0, enc_cfg.pos_limit};
            REG_VEL_LIMIT:    want = {1'b0, enc_cfg.vel_limit};
            REG_TORQUE_LIMIT: want = {1'b0, enc_cfg.torque_limit};
            REG_STIFF_MIN:    want = enc_cfg.stiff_min;
            REG_STIFF_MAX:    want = enc_cfg.stiff_max;
            REG_DAMP_MIN:     want = enc_cfg.damp_min;
            REG_DAMP_MAX:     want = enc_cfg.damp_max;
            default:          want = {21'd0, enc_cfg.frame_id};
        endcase
        if (rd !== want)
            report_mismatch(idx.name(), 64'(rd), 64'(want));
    endtask

    // block idle: nothing queued or in flight, then let the pipeline settle
    task automatic wait_drained();
        do
            @(negedge clk);
        while (cmd_q.size() != 0 || s_tvalid || frame_q.size() != 0);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    // command driver with random idle bursts
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || in_taken)
        begin
            if (in_gap != 0)
            begin
                in_gap   <= in_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (cmd_q.size() != 0 && idle_on && $urandom_range(0, 7) == 0)
            begin
                in_gap   <= $urandom_range(0, 8);
                s_tvalid <= 1'b0;
            end
            else if (cmd_q.size() != 0)
            begin
                s_tdata  <= cmd_q.pop_front();
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // frame receiver stalls in random bursts
    always @(negedge clk)
    begin
        if (out_gap != 0)
        begin
            out_gap  <= out_gap - 1;
            m_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            out_gap  <= $urandom_range(0, 8);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // monitor: check each frame word, then predict from each accepted command word
    always @(posedge clk)
    begin
        frame_t got;
        frame_t want;
        in_taken <= s_tvalid && s_tready;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = frame_t'(m_tdata);
                frames_seen++;
                if (frame_q.size() == 0)
                    report_mismatch("frame with no command pending", 64'(m_tdata), '0);
                else
                begin
                    want = frame_q.pop_front();
                    if (got.out_id !== want.out_id)
                        report_mismatch("out_id", 64'(got.out_id), 64'(want.out_id));
                    if (got.byte0 !== want.byte0)
                        report_mismatch("byte0", 64'(got.byte0), 64'(want.byte0));
                    if (got.byte1 !== want.byte1)
                        report_mismatch("byte1", 64'(got.byte1), 64'(want.byte1));
                    if (got.byte2 !== want.byte2)
                        report_mismatch("byte2", 64'(got.byte2), 64'(want.byte2));
                    if (got.byte3 !== want.byte3)
                        report_mismatch("byte3", 64'(got.byte3), 64'(want.byte3));
                    if (got.byte4 !== want.byte4)
                        report_mismatch("byte4", 64'(got.byte4), 64'(want.byte4));
                    if (got.byte5 !== want.byte5)
                        report_mismatch("byte5", 64'(got.byte5), 64'(want.byte5));
                    if (got.byte6 !== want.byte6)
                        report_mismatch("byte6", 64'(got.byte6), 64'(want.byte6));
                    if (got.byte7 !== want.byte7)
                        report_mismatch("byte7", 64'(got.byte7), 64'(want.byte7));
                    if (got.pad !== want.pad)
                        report_mismatch("pad", 64'(got.pad), 64'(want.pad));
                end
            end
            if (s_tvalid && s_tready)
            begin
                frame_q.push_back(encode_frame(cmd_t'(s_tdata)));
                cmds_sent++;
            end
        end
    end

    // stimulus: reset, directed commands, then register settings with random commands
    initial
    begin
        logic [31:0] setting [8];
        enc_cfg.pos_limit    = POS_LIMIT_RST;
        enc_cfg.vel_limit    = VEL_LIMIT_RST;
        enc_cfg.torque_limit = TORQUE_LIMIT_RST;
        enc_cfg.stiff_min    = STIFF_MIN_RST;
        enc_cfg.stiff_max    = STIFF_MAX_RST;
        enc_cfg.damp_min     = DAMP_MIN_RST;
        enc_cfg.damp_max     = DAMP_MAX_RST;
        enc_cfg.frame_id     = FRAME_ID_RST;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        for (int r = 0; r < 8; r++)
            check_reg(reg_idx_t'(r));

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph > 0)
            begin
                wait_drained();
                case (ph)
                    // widest ranges; top bits above each width must be dropped
                    1: setting = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
                                   32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
                    // every range empty: zero limits, equal or swapped bounds
                    2: setting = '{32'd0, 32'h8000_0000, 32'd0, 32'd5, 32'd5, 32'd100,
                                   -32'sd100, 32'd0};
                    // narrowest non-empty ranges
                    3: setting = '{32'd1, 32'd1, 32'd1, 32'd0, 32'd1, -32'sd1, 32'd0,
                                   $urandom};
                    default:
                    begin
                        for (int r = 0; r < 3; r++)
                            setting[r] = $urandom >> $urandom_range(0, 31);
                        setting[3] = $signed($urandom) >>> $urandom_range(0, 31);
                        setting[4] = setting[3] + ($urandom >> $urandom_range(0, 31));
                        setting[5] = $signed($urandom) >>> $urandom_range(0, 31);
                        setting[6] = setting[5] + ($urandom >> $urandom_range(0, 31));
                        setting[7] = $urandom;
                    end
                endcase
                for (int r = 0; r < 8; r++)
                    write_reg(reg_idx_t'(r), setting[r]);
                for (int r = 0; r < 8; r++)
                    check_reg(reg_idx_t'(r));
            end
            // some phases run without idling, the last one always does
            idle_on = (ph != NUM_PHASES - 1) && (ph % 3 != 2);
            if (ph == 0)
            begin
                // field extremes, range edges and clamping on the reset ranges
                push_cmd(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
                push_cmd(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         32'h7FFF_FFFF);
                push_cmd(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h8000_0000);
                push_cmd(32'd819200, 32'd1966080, 32'd32768000, 32'd327680, 32'd655360);
                push_cmd(-32'sd819200, -32'sd1966080, 32'd0, 32'd0, -32'sd655360);
                push_cmd(32'd819201, -32'sd1966081, 32'd32768001, -32'sd1, 32'd655361);
                push_cmd(32'd819199, -32'sd1966079, 32'd32767999, 32'd1, -32'sd655359);
                push_cmd(-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1);
                push_cmd(32'd1, 32'd1, 32'd1, 32'd1, 32'd1);
                push_cmd(32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
                         32'hAAAA_AAAA);
                push_cmd(32'h5555_5555, 32'h5555_5555, 32'h5555_5555, 32'h5555_5555,
                         32'h5555_5555);
                push_cmd(32'd12345, -32'sd54321, 32'd16384000, 32'd163840, -32'sd327680);
                push_cmd(-32'sd819199, 32'd1966079, 32'd1, 32'd327679, 32'd655359);
            end
            for (int i = 0; i < PHASE_CMDS + ((ph == 0) ? 10 : 0); i++)
                cmd_q.push_back(random_cmd());
        end

        wait_drained();
        $display("sent %0d commands, checked %0d frames", cmds_sent, frames_seen);
        $display("covered %0d register settings incl. widest, empty and narrowest ranges",
                 NUM_PHASES);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // run limit, far above the slowest correct run
    initial
    begin
        #5_000_000;
        $display("timeout: %0d frames still pending", frame_q.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule
